@@ sv/lkv_pkg.sv @@
`timescale 1ns / 1ps

package lkv_pkg;

    // Default sizing
    localparam int DEF_CAPACITY   = 16;
    localparam int DEF_VALUE_BITS = 32;

    // Fixed field widths
    localparam int KIND_W    = 3;
    localparam int KEY_W     = 32;
    localparam int NV_W      = 32;
    localparam int RV_W      = 32;
    localparam int STATUS_W  = 2;
    localparam int ECNT_W    = 5;
    localparam int S_TDATA_W = 64;
    localparam int M_TDATA_W = 40;

    // Operation kinds
    localparam logic [KIND_W-1:0] KIND_WRITE  = 3'd0;
    localparam logic [KIND_W-1:0] KIND_ACCESS = 3'd1;
    localparam logic [KIND_W-1:0] KIND_LOOKUP = 3'd2;
    localparam logic [KIND_W-1:0] KIND_DELETE = 3'd3;
    localparam logic [KIND_W-1:0] KIND_CLEAR  = 3'd4;

    // Result status codes
    localparam logic [STATUS_W-1:0] STATUS_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_NOTFOUND = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_FULL     = 2'd2;

    // Sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_RD,
        ST_CMP,
        ST_SH_RD,
        ST_SH_WR,
        ST_MISS,
        ST_DONE
    } state_t;

endpackage

@@ sv/linear_key_value_table_core.sv @@
`timescale 1ns / 1ps
// Linear key-value table: a fixed-capacity table of key/value entries kept
// in insertion order and searched one entry at a time.
// Input stream (s_*): one transfer carries kind in s_tuser and key plus
// new_value in s_tdata. Kinds: write, access-or-insert, lookup, delete,
// clear. Result stream (m_*): exactly one transfer per input transfer with
// read_value, hit, status and the entry count after the operation.
// Timing: the search reads the key and value memories at one address per
// step; each stored entry examined takes a registered read, then a compare.
// A miss adds a step that appends on insert kinds or flags a failed delete.
// A delete then copies every later entry one place down through the same
// memory port. Clear and unused kinds go straight to the result.
// s_tready is high only while the sequencer is idle; one operation is in
// work at a time. The result sits in an output register, so the next
// transfer is taken while a result still waits for m_tready; a stalled
// receiver only holds the block once a further result is ready.
// Reset (aresetn low, synchronous) empties the table and drops any pending
// result; the memories are not cleared, as only entries below the count
// are ever read.
module linear_key_value_table_core #(
    parameter int CAPACITY   = lkv_pkg::DEF_CAPACITY,
    parameter int VALUE_BITS = lkv_pkg::DEF_VALUE_BITS
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [lkv_pkg::S_TDATA_W-1:0] s_tdata,  // [31:0] key, [63:32] new_value
    input  logic [lkv_pkg::KIND_W-1:0]    s_tuser,  // [2:0] kind
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [lkv_pkg::M_TDATA_W-1:0] m_tdata   // [31:0] read_value, [32] hit,
                                                    // [34:33] status, [39:35] entry_count
);
    import lkv_pkg::*;

    localparam int IW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);

    state_t state_reg, state_next;

    logic [KIND_W-1:0]    kind_reg, kind_next;
    logic [KEY_W-1:0]     key_reg, key_next;
    logic [NV_W-1:0]      nv_reg, nv_next;
    logic [IW-1:0]        idx_reg, idx_next;
    logic [CW-1:0]        count_reg, count_next;
    logic [RV_W-1:0]      rv_reg, rv_next;
    logic                 hit_reg, hit_next;
    logic [STATUS_W-1:0]  status_reg, status_next;
    logic                 m_tvalid_reg, m_tvalid_next;
    logic [M_TDATA_W-1:0] m_tdata_reg, m_tdata_next;

    // Memory port signals
    logic                  rd_en;
    logic [IW-1:0]         rd_addr;
    logic                  key_we;
    logic [IW-1:0]         key_waddr;
    logic [KEY_W-1:0]      key_wdata;
    logic [KEY_W-1:0]      key_rdata;
    logic                  val_we;
    logic [IW-1:0]         val_waddr;
    logic [VALUE_BITS-1:0] val_wdata;
    logic [VALUE_BITS-1:0] val_rdata;

    // Width conversions between 32-bit fields and stored values
    logic [VALUE_BITS+NV_W-1:0] nv_wide;
    logic [VALUE_BITS-1:0]      nv_ext;
    logic [VALUE_BITS+RV_W-1:0] nv_back_wide;
    logic [RV_W-1:0]            nv_kept;
    logic [VALUE_BITS+RV_W-1:0] rd_wide;
    logic [RV_W-1:0]            val_rd32;
    logic [CW+ECNT_W-1:0]       cnt_wide;

    logic [CW-1:0] idx_p1;
    logic          key_match;
    logic          table_full;
    logic          out_free;

    assign nv_wide      = {{VALUE_BITS{1'b0}}, nv_reg};
    assign nv_ext       = nv_wide[VALUE_BITS-1:0];
    assign nv_back_wide = {{RV_W{1'b0}}, nv_ext};
    assign nv_kept      = nv_back_wide[RV_W-1:0];
    assign rd_wide      = {{RV_W{1'b0}}, val_rdata};
    assign val_rd32     = rd_wide[RV_W-1:0];
    assign cnt_wide     = {{ECNT_W{1'b0}}, count_reg};

    assign idx_p1     = CW'(idx_reg) + CW'(1);
    assign key_match  = (key_rdata == key_reg);
    assign table_full = (count_reg >= CW'(CAPACITY));
    assign out_free   = !m_tvalid_reg || m_tready;

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // Key and value stores
    lkv_ram #(
        .WIDTH (KEY_W),
        .DEPTH (CAPACITY)
    ) u_key_ram (
        .clk   (aclk),
        .we    (key_we),
        .waddr (key_waddr),
        .wdata (key_wdata),
        .re    (rd_en),
        .raddr (rd_addr),
        .rdata (key_rdata)
    );

    lkv_ram #(
        .WIDTH (VALUE_BITS),
        .DEPTH (CAPACITY)
    ) u_val_ram (
        .clk   (aclk),
        .we    (val_we),
        .waddr (val_waddr),
        .wdata (val_wdata),
        .re    (rd_en),
        .raddr (rd_addr),
        .rdata (val_rdata)
    );

    // Next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    if (s_tuser inside {KIND_WRITE, KIND_ACCESS, KIND_LOOKUP, KIND_DELETE}) begin
                        state_next = (count_reg == '0) ? ST_MISS : ST_RD;
                    end else begin
                        state_next = ST_DONE;
                    end
                end
            end
            ST_RD: begin
                state_next = ST_CMP;
            end
            ST_CMP: begin
                if (key_match) begin
                    state_next = (kind_reg == KIND_DELETE && idx_p1 < count_reg) ?
                                 ST_SH_RD : ST_DONE;
                end else begin
                    state_next = (idx_p1 < count_reg) ? ST_RD : ST_MISS;
                end
            end
            ST_SH_RD: begin
                state_next = ST_SH_WR;
            end
            ST_SH_WR: begin
                state_next = (idx_p1 < count_reg) ? ST_SH_RD : ST_DONE;
            end
            ST_MISS: begin
                state_next = ST_DONE;
            end
            ST_DONE: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Datapath and memory control
    always_comb begin
        kind_next     = kind_reg;
        key_next      = key_reg;
        nv_next       = nv_reg;
        idx_next      = idx_reg;
        count_next    = count_reg;
        rv_next       = rv_reg;
        hit_next      = hit_reg;
        status_next   = status_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        m_tdata_next  = m_tdata_reg;
        rd_en         = 1'b0;
        rd_addr       = idx_reg;
        key_we        = 1'b0;
        key_waddr     = idx_reg;
        key_wdata     = key_reg;
        val_we        = 1'b0;
        val_waddr     = idx_reg;
        val_wdata     = nv_ext;

        unique case (state_reg)
            ST_IDLE: begin
                // Take the operation and start a fresh result
                if (s_tvalid) begin
                    kind_next   = s_tuser;
                    key_next    = s_tdata[KEY_W-1:0];
                    nv_next     = s_tdata[KEY_W+NV_W-1:KEY_W];
                    idx_next    = '0;
                    rv_next     = '0;
                    hit_next    = 1'b0;
                    status_next = STATUS_OK;
                    if (s_tuser == KIND_CLEAR) begin
                        count_next = '0;
                    end
                end
            end
            ST_RD: begin
                rd_en = 1'b1;
            end
            ST_CMP: begin
                // Resolve a hit, or advance to the next entry
                if (key_match) begin
                    hit_next = 1'b1;
                    case (kind_reg)
                        KIND_WRITE: begin
                            val_we  = 1'b1;
                            rv_next = nv_kept;
                        end
                        KIND_DELETE: begin
                            rv_next    = val_rd32;
                            count_next = count_reg - CW'(1);
                        end
                        default: begin
                            rv_next = val_rd32;
                        end
                    endcase
                end else if (idx_p1 < count_reg) begin
                    idx_next = idx_reg + IW'(1);
                end
            end
            ST_SH_RD: begin
                rd_en   = 1'b1;
                rd_addr = idx_p1[IW-1:0];
            end
            ST_SH_WR: begin
                // Move the later entry down one place
                key_we    = 1'b1;
                key_wdata = key_rdata;
                val_we    = 1'b1;
                val_wdata = val_rdata;
                idx_next  = idx_reg + IW'(1);
            end
            ST_MISS: begin
                // Append on insert kinds or flag a full table, flag a failed delete
                case (kind_reg)
                    KIND_WRITE, KIND_ACCESS: begin
                        if (table_full) begin
                            status_next = STATUS_FULL;
                        end else begin
                            key_we     = 1'b1;
                            key_waddr  = count_reg[IW-1:0];
                            val_we     = 1'b1;
                            val_waddr  = count_reg[IW-1:0];
                            val_wdata  = (kind_reg == KIND_WRITE) ? nv_ext : '0;
                            rv_next    = (kind_reg == KIND_WRITE) ? nv_kept : '0;
                            count_next = count_reg + CW'(1);
                        end
                    end
                    KIND_DELETE: begin
                        status_next = STATUS_NOTFOUND;
                    end
                    default: begin
                    end
                endcase
            end
            ST_DONE: begin
                // Load the result register once it is free
                if (out_free) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {cnt_wide[ECNT_W-1:0], status_reg, hit_reg, rv_reg};
                end
            end
            default: begin
            end
        endcase
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            count_reg    <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        kind_reg    <= kind_next;
        key_reg     <= key_next;
        nv_reg      <= nv_next;
        idx_reg     <= idx_next;
        rv_reg      <= rv_next;
        hit_reg     <= hit_next;
        status_reg  <= status_next;
        m_tdata_reg <= m_tdata_next;
    end

    // Checks
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CW'(CAPACITY))
        else $error("entry count above capacity");

    a_search_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_CMP) |-> (idx_p1 <= count_reg))
        else $error("search read beyond valid entries");

    a_hit_status: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DONE) |-> !(hit_reg && status_reg != STATUS_OK))
        else $error("hit reported with a failure status");

    a_full_status: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DONE && status_reg == STATUS_FULL) |-> table_full)
        else $error("full status while table has room");

    a_clear_empties: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready && s_tuser == KIND_CLEAR) |=> (count_reg == '0))
        else $error("clear left entries behind");

endmodule

@@ sv/lkv_ram.sv @@
`timescale 1ns / 1ps

module lkv_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port
    always_ff @(posedge clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port, holds its data when idle
    always_ff @(posedge clk) begin
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule
